// ===== rtl/jws_pkg.sv =====
// Shared types and constants for the Jaro-Winkler similarity unit.
package jws_pkg;

    localparam int CHAR_W   = 21;   // width of the char_code field
    localparam int CMD_AW   = 10;   // address room in a command (MAX_LEN up to 1024)
    localparam int CMD_LW   = 11;   // length room in a command
    localparam int FRAC_W   = 16;   // Q1.16 fraction bits

    localparam logic [16:0] ONE_Q16     = 17'h10000;
    localparam logic [14:0] SCALE_RESET = 15'd6554;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              second_string;
        logic              char_present;
        logic              end_of_string;
    } jws_in_t;

    typedef struct packed {
        logic [16:0] similarity;
        logic [6:0]  match_count;
        logic [5:0]  transposition_count;
        logic        truncated;
    } jws_out_t;

    // Command from the front end to the engine.
    typedef struct packed {
        logic              wr;
        logic              to_second;
        logic [CMD_AW-1:0] addr;
        logic [CHAR_W-1:0] code;
        logic              eval;
        logic [CMD_LW-1:0] len_a;
        logic [CMD_LW-1:0] len_b;
        logic              ovf;
    } jws_cmd_t;

endpackage

// ===== rtl/jws_fifo.sv =====
// Small register queue between the front end and the engine.
module jws_fifo
    import jws_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  jws_cmd_t wr_data,
    output logic     full,
    input  logic     rd_en,
    output jws_cmd_t rd_data,
    output logic     empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jws_cmd_t        slots_reg [DEPTH];
    logic [PW-1:0]   wp_reg;
    logic [PW-1:0]   rp_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_wr;
    logic            do_rd;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = slots_reg[rp_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_rd)
            begin
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/jws_front.sv =====
// Front end: takes input transactions, tracks string lengths, issues commands.
module jws_front
    import jws_pkg::*;
#(
    parameter int MAX_LEN   = 64,
    parameter int CHAR_BITS = 21
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  jws_in_t  item,
    output logic     full,
    output logic     cmd_push,
    output jws_cmd_t cmd,
    input  logic     cmd_full
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CB = (CHAR_BITS < CHAR_W) ? CHAR_BITS : CHAR_W;

    logic [LW-1:0] len_a_reg, len_a_next;
    logic [LW-1:0] len_b_reg, len_b_next;
    logic          ovf_reg, ovf_next;
    logic          accept;
    logic          room;
    logic [LW-1:0] cur_len;

    assign full    = cmd_full;
    assign accept  = push && !cmd_full;
    assign cur_len = item.second_string ? len_b_reg : len_a_reg;
    assign room    = (cur_len < LW'(MAX_LEN));

    always_comb
    begin
        len_a_next = len_a_reg;
        len_b_next = len_b_reg;
        ovf_next   = ovf_reg;
        if (item.char_present)
        begin
            if (!room)
            begin
                ovf_next = 1'b1;
            end
            else if (item.second_string)
            begin
                len_b_next = len_b_reg + 1'b1;
            end
            else
            begin
                len_a_next = len_a_reg + 1'b1;
            end
        end

        cmd.wr        = item.char_present && room;
        cmd.to_second = item.second_string;
        cmd.addr      = CMD_AW'(cur_len);
        cmd.code      = CHAR_W'(item.char_code[CB-1:0]);
        cmd.eval      = item.end_of_string && item.second_string;
        cmd.len_a     = CMD_LW'(len_a_next);
        cmd.len_b     = CMD_LW'(len_b_next);
        cmd.ovf       = ovf_next;
        cmd_push      = accept && (cmd.wr || cmd.eval);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg <= '0;
            len_b_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (cmd.eval)
            begin
                len_a_reg <= '0;
                len_b_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                len_a_reg <= len_a_next;
                len_b_reg <= len_b_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

// ===== rtl/jws_engine.sv =====
// Engine: string memories, match search, transpositions, prefix, Q1.16 math.
module jws_engine
    import jws_pkg::*;
#(
    parameter int MAX_LEN    = 64,
    parameter int CHAR_BITS  = 21,
    parameter int PREFIX_MAX = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  jws_cmd_t    cmd,
    input  logic        cmd_empty,
    output logic        cmd_pop,
    input  logic [14:0] prefix_scale,
    output jws_out_t    result,
    output logic        empty,
    input  logic        pop
);

    localparam int LW     = $clog2(MAX_LEN + 1);
    localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CB     = (CHAR_BITS < CHAR_W) ? CHAR_BITS : CHAR_W;
    localparam int MM_W   = 2 * LW;
    localparam int P1_W   = 3 * LW + 1;
    localparam int P2_W   = 3 * LW;
    localparam int DEN_W  = 3 * LW;
    localparam int NUM_W  = 3 * LW + 2;
    localparam int DVS_W  = DEN_W + 3;
    localparam int DVD_W  = NUM_W + 18;
    localparam int DC_W   = $clog2(DVD_W + 1);
    localparam int PR1_W  = LW + 15;
    localparam int PR2_W  = PR1_W + 17;
    localparam int SUM_W  = PR2_W + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_MNEXT, S_MREAD, S_MCMP, S_TNEXT, S_TREAD, S_TCMP,
        S_PREAD, S_PCMP, S_AR1, S_AR2, S_AR3, S_DIV, S_BN1, S_BN2, S_BN3, S_DONE
    } state_t;

    logic [CB-1:0] first_mem  [MAX_LEN];
    logic [CB-1:0] second_mem [MAX_LEN];
    logic [CB-1:0] f_rd_reg, s_rd_reg;
    logic [AW-1:0] f_addr, s_addr;

    state_t             state_reg;
    logic [LW-1:0]      a_reg, b_reg, range_reg;
    logic [LW-1:0]      i_reg, j_reg, k_reg, hi_reg, l_reg, lim_reg;
    logic [LW-1:0]      m_reg, oo_reg, t_reg;
    logic [MAX_LEN-1:0] fm_reg, sm_reg;
    logic               ovf_reg;
    logic [MM_W-1:0]    mm_reg, ab_reg;
    logic [P1_W-1:0]    p1_reg;
    logic [P2_W-1:0]    p2_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DVD_W-1:0]   dvd_reg, q_reg;
    logic [DVS_W-1:0]   dvs_reg, rem_reg;
    logic [DC_W-1:0]    dcnt_reg;
    logic [16:0]        jaro_reg, sim_reg;
    logic [PR1_W-1:0]   prod1_reg;
    logic [PR2_W-1:0]   prod2_reg;
    logic               res_valid_reg;
    jws_out_t           res_reg;

    // combinational helpers
    logic [LW-1:0]    lo_c, hi_c, longest_c, lim_c;
    logic [LW:0]      hi_sum;
    logic [LW-1:0]    cmd_a, cmd_b;
    logic [NUM_W-1:0] num_c;
    logic [DVS_W-1:0] den3_c;
    logic [DVS_W:0]   trial_c;
    logic             trial_ge;
    logic [SUM_W-1:0] sum_c;
    logic [PR2_W-1:0] bonus_c;

    assign cmd_a   = cmd.len_a[LW-1:0];
    assign cmd_b   = cmd.len_b[LW-1:0];
    assign cmd_pop = (state_reg == S_IDLE) && !cmd_empty;
    assign empty   = !res_valid_reg;
    assign result  = res_reg;

    always_comb
    begin
        lo_c      = (i_reg > range_reg) ? i_reg - range_reg : '0;
        hi_sum    = (LW+1)'(i_reg) + (LW+1)'(range_reg) + 1'b1;
        hi_c      = (hi_sum > (LW+1)'(a_reg)) ? a_reg : hi_sum[LW-1:0];
        longest_c = (cmd_a > cmd_b) ? cmd_a : cmd_b;
        lim_c     = (a_reg < b_reg) ? a_reg : b_reg;
        if (int'(lim_c) > PREFIX_MAX)
        begin
            lim_c = LW'(PREFIX_MAX);
        end
        num_c    = NUM_W'(p1_reg) + NUM_W'(p2_reg);
        den3_c   = DVS_W'(den_reg) + (DVS_W'(den_reg) << 1);
        trial_c  = {rem_reg, dvd_reg[DVD_W-1]};
        trial_ge = (trial_c >= {1'b0, dvs_reg});
        bonus_c  = (prod2_reg + PR2_W'(32768)) >> FRAC_W;
        sum_c    = SUM_W'(jaro_reg) + SUM_W'(bonus_c);
        case (state_reg)
            S_MREAD:
            begin
                f_addr = j_reg[AW-1:0];
                s_addr = i_reg[AW-1:0];
            end
            S_TREAD:
            begin
                f_addr = k_reg[AW-1:0];
                s_addr = i_reg[AW-1:0];
            end
            default:
            begin
                f_addr = l_reg[AW-1:0];
                s_addr = l_reg[AW-1:0];
            end
        endcase
    end

    // string storage, one write and one registered read per memory
    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.wr)
        begin
            if (cmd.to_second)
            begin
                second_mem[cmd.addr[AW-1:0]] <= cmd.code[CB-1:0];
            end
            else
            begin
                first_mem[cmd.addr[AW-1:0]] <= cmd.code[CB-1:0];
            end
        end
        f_rd_reg <= first_mem[f_addr];
        s_rd_reg <= second_mem[s_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            fm_reg        <= '0;
            sm_reg        <= '0;
        end
        else
        begin
            // a result loaded in S_DONE takes the place of the one popped
            if (pop && res_valid_reg && state_reg != S_DONE)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_pop && cmd.eval)
                    begin
                        a_reg     <= cmd_a;
                        b_reg     <= cmd_b;
                        ovf_reg   <= cmd.ovf;
                        fm_reg    <= '0;
                        sm_reg    <= '0;
                        m_reg     <= '0;
                        i_reg     <= '0;
                        range_reg <= ((longest_c >> 1) != '0) ? (longest_c >> 1) - 1'b1 : '0;
                        if (cmd_a == '0 || cmd_b == '0)
                        begin
                            sim_reg   <= '0;
                            t_reg     <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_MNEXT;
                        end
                    end
                end
                S_MNEXT:
                begin
                    if (i_reg == b_reg)
                    begin
                        i_reg  <= '0;
                        k_reg  <= '0;
                        oo_reg <= '0;
                        if (m_reg == '0)
                        begin
                            sim_reg   <= '0;
                            t_reg     <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_TNEXT;
                        end
                    end
                    else if (lo_c >= hi_c)
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        j_reg     <= lo_c;
                        hi_reg    <= hi_c;
                        state_reg <= S_MREAD;
                    end
                end
                S_MREAD:
                begin
                    state_reg <= S_MCMP;
                end
                S_MCMP:
                begin
                    if (!fm_reg[j_reg[AW-1:0]] && f_rd_reg == s_rd_reg)
                    begin
                        fm_reg[j_reg[AW-1:0]] <= 1'b1;
                        sm_reg[i_reg[AW-1:0]] <= 1'b1;
                        m_reg     <= m_reg + 1'b1;
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_MNEXT;
                    end
                    else if (j_reg + 1'b1 >= hi_reg)
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_MNEXT;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_MREAD;
                    end
                end
                S_TNEXT:
                begin
                    if (i_reg == b_reg)
                    begin
                        l_reg     <= '0;
                        lim_reg   <= lim_c;
                        state_reg <= S_PREAD;
                    end
                    else if (!sm_reg[i_reg[AW-1:0]])
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                    else if (k_reg < a_reg && !fm_reg[k_reg[AW-1:0]])
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                    else if (k_reg < a_reg)
                    begin
                        state_reg <= S_TREAD;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_TREAD:
                begin
                    state_reg <= S_TCMP;
                end
                S_TCMP:
                begin
                    if (f_rd_reg != s_rd_reg)
                    begin
                        oo_reg <= oo_reg + 1'b1;
                    end
                    k_reg     <= k_reg + 1'b1;
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= S_TNEXT;
                end
                S_PREAD:
                begin
                    state_reg <= S_PCMP;
                end
                S_PCMP:
                begin
                    if (f_rd_reg == s_rd_reg)
                    begin
                        l_reg     <= l_reg + 1'b1;
                        state_reg <= (l_reg + 1'b1 < lim_reg) ? S_PREAD : S_AR1;
                    end
                    else
                    begin
                        state_reg <= S_AR1;
                    end
                end
                S_AR1:
                begin
                    mm_reg    <= MM_W'(m_reg) * MM_W'(m_reg);
                    ab_reg    <= MM_W'(a_reg) * MM_W'(b_reg);
                    t_reg     <= oo_reg >> 1;
                    state_reg <= S_AR2;
                end
                S_AR2:
                begin
                    p1_reg    <= P1_W'(mm_reg) * P1_W'((LW+1)'(a_reg) + (LW+1)'(b_reg));
                    p2_reg    <= P2_W'(m_reg - t_reg) * P2_W'(ab_reg);
                    den_reg   <= DEN_W'(m_reg) * DEN_W'(ab_reg);
                    state_reg <= S_AR3;
                end
                S_AR3:
                begin
                    dvd_reg   <= (DVD_W'(num_c) << (FRAC_W + 1)) + DVD_W'(den3_c);
                    dvs_reg   <= den3_c << 1;
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    dcnt_reg  <= DC_W'(DVD_W);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // one quotient bit per cycle
                    rem_reg  <= trial_ge ? DVS_W'(trial_c - {1'b0, dvs_reg})
                                         : trial_c[DVS_W-1:0];
                    q_reg    <= {q_reg[DVD_W-2:0], trial_ge};
                    dvd_reg  <= dvd_reg << 1;
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == DC_W'(1))
                    begin
                        state_reg <= S_BN1;
                    end
                end
                S_BN1:
                begin
                    jaro_reg  <= (q_reg > DVD_W'(ONE_Q16)) ? ONE_Q16 : q_reg[16:0];
                    prod1_reg <= PR1_W'(l_reg) * PR1_W'(prefix_scale);
                    state_reg <= S_BN2;
                end
                S_BN2:
                begin
                    prod2_reg <= PR2_W'(prod1_reg) * PR2_W'(ONE_Q16 - jaro_reg);
                    state_reg <= S_BN3;
                end
                S_BN3:
                begin
                    sim_reg   <= (sum_c > SUM_W'(ONE_Q16)) ? ONE_Q16 : sum_c[16:0];
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!res_valid_reg || pop)
                    begin
                        res_reg.similarity          <= sim_reg;
                        res_reg.match_count         <= (int'(m_reg) > 127) ? 7'd127
                                                       : 7'(m_reg);
                        res_reg.transposition_count <= (int'(t_reg) > 63) ? 6'd63
                                                       : 6'(t_reg);
                        res_reg.truncated           <= ovf_reg;
                        res_valid_reg               <= 1'b1;
                        state_reg                   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/jaro_winkler_similarity_unit.sv =====
// Top level of the Jaro-Winkler similarity unit.
//
//  channel   ports                   handshake
//  -------   ---------------------   ---------------------------------
//  input     item, push, full        transaction when push && !full
//  result    result, empty, pop      transaction when pop && !empty
//  config    cfg_we, cfg_data        prefix_scale written when cfg_we
//
//  A character transaction passes from the front end through the command
//  queue into engine memory. The final transaction of the second string
//  starts an evaluation: the match search (engine memory read then compare
//  for each window position), the transposition walk, the prefix compare,
//  the multiply stages, a restoring divider that yields one quotient bit per
//  cycle (3*clog2(MAX_LEN+1)+20 bits), and the bonus steps that finish.
//  Reset is asynchronous and clears control state and sets prefix_scale to
//  0.1; string memories need no clearing. The command queue lets input keep
//  arriving while the engine works until the queue fills, and the result
//  register holds one finished result while the next evaluation runs; the
//  engine waits at its last step if that register is still occupied.
module jaro_winkler_similarity_unit
    import jws_pkg::*;
#(
    parameter int MAX_LEN    = 64,
    parameter int CHAR_BITS  = 21,
    parameter int PREFIX_MAX = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  jws_in_t     item,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output jws_out_t    result,
    input  logic        cfg_we,
    input  logic [14:0] cfg_data
);

    logic [14:0] prefix_scale_reg;
    jws_cmd_t    fe_cmd;
    jws_cmd_t    q_cmd;
    logic        fe_push;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_scale_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            prefix_scale_reg <= cfg_data;
        end
    end

    // front end: string lengths, overflow, command formation
    jws_front #(
        .MAX_LEN   (MAX_LEN),
        .CHAR_BITS (CHAR_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .cmd_push (fe_push),
        .cmd      (fe_cmd),
        .cmd_full (q_full)
    );

    // decoupling queue
    jws_fifo #(
        .DEPTH (2)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fe_push),
        .wr_data (fe_cmd),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_cmd),
        .empty   (q_empty)
    );

    // back end: storage and evaluation
    jws_engine #(
        .MAX_LEN    (MAX_LEN),
        .CHAR_BITS  (CHAR_BITS),
        .PREFIX_MAX (PREFIX_MAX)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (q_cmd),
        .cmd_empty    (q_empty),
        .cmd_pop      (q_pop),
        .prefix_scale (prefix_scale_reg),
        .result       (result),
        .empty        (empty),
        .pop          (pop)
    );

    a_sim_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.similarity <= ONE_Q16)
        else $error("similarity above 1.0");

    a_trans_vs_match: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> {result.transposition_count, 1'b0} <= 7'(result.match_count))
        else $error("transpositions exceed half the matches");

    a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.match_count == 7'd0) |-> result.similarity == 17'd0)
        else $error("nonzero similarity without matches");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result lost or changed");

endmodule

// ===== tb/sv/jaro_winkler_similarity_unit_tb.sv =====
// Testbench for the Jaro-Winkler similarity unit: directed and random string pairs.
module jaro_winkler_similarity_unit_tb;
    import jws_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STR_MAX    = 64;
    localparam int PFX_MAX    = 4;
    localparam int RAND_ITEMS = 900;
    localparam int SETTLE     = 200;   // cycles for the engine to go quiet

    logic        clk;
    logic        rst_n;
    logic        push;
    jws_in_t     item;
    logic        full;
    logic        empty;
    logic        pop;
    jws_out_t    result;
    logic        cfg_we;
    logic [14:0] cfg_data;

    // Predictor state: the strings as collected so far and the live scale.
    logic [CHAR_W-1:0] str_a [STR_MAX];
    logic [CHAR_W-1:0] str_b [STR_MAX];
    int                len_a;
    int                len_b;
    bit                cut_seen;
    logic [14:0]       scale;

    jws_out_t score_q[$];      // similarity results still owed by the block
    int       mismatches;
    int       items_sent;
    bit       steady_in;       // no gaps on the input side while set
    bit       steady_out;      // no stalls on the result side while set

    jaro_winkler_similarity_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Jaro-Winkler of the collected pair, greedy match search inside the window.
    function automatic jws_out_t jw_score();
        bit              hit_a [STR_MAX];
        bit              hit_b [STR_MAX];
        int              m, swaps, t, span, lo, hi, k, lim, pfx;
        longint unsigned mm, num, den, jaro, bonus, sim;
        jws_out_t        r;
        m = 0;
        swaps = 0;
        sim = 0;
        foreach (hit_a[i])
        begin
            hit_a[i] = 1'b0;
            hit_b[i] = 1'b0;
        end
        if (len_a != 0 && len_b != 0)
        begin
            span = ((len_a > len_b ? len_a : len_b) / 2 >= 1) ?
                   (len_a > len_b ? len_a : len_b) / 2 - 1 : 0;
            for (int i = 0; i < len_b; i++)
            begin
                lo = i > span ? i - span : 0;
                hi = i + span + 1;
                if (hi > len_a)
                    hi = len_a;
                for (int j = lo; j < hi; j++)
                begin
                    if (!hit_a[j] && str_a[j] == str_b[i])
                    begin
                        hit_a[j] = 1'b1;
                        hit_b[i] = 1'b1;
                        m++;
                        break;
                    end
                end
            end
        end
        // Walk matched characters of both strings in order.
        k = 0;
        if (m != 0)
        begin
            for (int i = 0; i < len_b; i++)
            begin
                if (hit_b[i])
                begin
                    while (k < len_a && !hit_a[k])
                        k++;
                    if (k < len_a)
                    begin
                        if (str_a[k] != str_b[i])
                            swaps++;
                        k++;
                    end
                end
            end
        end
        t = swaps / 2;
        if (m != 0)
        begin
            mm   = longint'(m) * m;
            num  = mm * len_b + mm * len_a + longint'(m - t) * len_a * len_b;
            den  = longint'(m) * len_a * len_b;
            jaro = (2 * num * 65536 + 3 * den) / (6 * den);
            if (jaro > 65536)
                jaro = 65536;
            lim = len_a < len_b ? len_a : len_b;
            if (lim > PFX_MAX)
                lim = PFX_MAX;
            pfx = 0;
            while (pfx < lim && str_a[pfx] == str_b[pfx])
                pfx++;
            bonus = (longint'(pfx) * scale * (65536 - jaro) + 32768) >> 16;
            sim = jaro + bonus;
            if (sim > 65536)
                sim = 65536;
        end
        else
        begin
            t = 0;
        end
        r.similarity          = sim[16:0];
        r.match_count         = m[6:0];
        r.transposition_count = t[5:0];
        r.truncated           = cut_seen;
        return r;
    endfunction

    // Apply one accepted transaction to the predictor.
    task automatic absorb(jws_in_t x);
        if (x.char_present)
        begin
            if (x.second_string)
            begin
                if (len_b < STR_MAX)
                begin
                    str_b[len_b] = x.char_code;
                    len_b++;
                end
                else
                    cut_seen = 1'b1;
            end
            else
            begin
                if (len_a < STR_MAX)
                begin
                    str_a[len_a] = x.char_code;
                    len_a++;
                end
                else
                    cut_seen = 1'b1;
            end
        end
        if (x.end_of_string && x.second_string)
        begin
            score_q.push_back(jw_score());
            len_a = 0;
            len_b = 0;
            cut_seen = 1'b0;
        end
    endtask

    // Send one item; push stays high afterward so back-to-back items need no gap.
    task automatic send_item(logic [CHAR_W-1:0] code, bit second, bit present, bit last);
        int      gap;
        jws_in_t x;
        logic    stall;
        x.char_code     = code;
        x.second_string = second;
        x.char_present  = present;
        x.end_of_string = last;
        gap = steady_in ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= x;
        // full is registered, so its mid-cycle value is the one seen at the edge
        do
        begin
            @(negedge clk);
            stall = full;
            @(posedge clk);
        end
        while (stall !== 1'b0);
        absorb(x);
        items_sent++;
    endtask

    // One whole string; an empty one is closed by an item with no character.
    task automatic send_string(logic [CHAR_W-1:0] s[$], bit second);
        if (s.size() == 0)
            send_item(CHAR_W'($urandom()), second, 1'b0, 1'b1);
        else
            foreach (s[i])
                send_item(s[i], second, 1'b1, i == s.size() - 1);
    endtask

    task automatic send_pair(logic [CHAR_W-1:0] sa[$], logic [CHAR_W-1:0] sb[$]);
        send_string(sa, 1'b0);
        send_string(sb, 1'b1);
    endtask

    // Drain every owed result, then let the engine settle.
    task automatic wait_quiet();
        push <= 1'b0;
        while (score_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_scale(logic [14:0] v);
        wait_quiet();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        scale = v;
    endtask

    // Extremes, classic examples and each corner the block has to handle.
    task automatic test_directed();
        logic [CHAR_W-1:0] sa[$];
        logic [CHAR_W-1:0] sb[$];
        // MARTHA / MARHTA: one transposition, prefix bonus over MAR
        sa = '{"M", "A", "R", "T", "H", "A"};
        sb = '{"M", "A", "R", "H", "T", "A"};
        send_pair(sa, sb);
        // identical strings at the code extremes
        sa = '{21'h0, 21'h1FFFFF, 21'h155555, 21'h0AAAAA};
        send_pair(sa, sa);
        // nothing matches
        sa = '{21'h1};
        sb = '{21'h2, 21'h3};
        send_pair(sa, sb);
        // empty first, empty second, both empty
        sb = {};
        send_pair(sb, sa);
        send_pair(sa, sb);
        send_pair(sb, sb);
        // interleaved items: strings grow in whatever order items arrive
        send_item("A", 1'b1, 1'b1, 1'b0);
        send_item("B", 1'b0, 1'b1, 1'b0);
        send_item("B", 1'b1, 1'b1, 1'b0);
        send_item("A", 1'b0, 1'b1, 1'b1);
        send_item("C", 1'b0, 1'b1, 1'b0);   // first string continues past its end mark
        send_item("C", 1'b1, 1'b1, 1'b1);
    endtask

    // Overlong strings are cut and flagged.
    task automatic test_truncation();
        logic [CHAR_W-1:0] sa[$];
        logic [CHAR_W-1:0] sb[$];
        sa = {};
        sb = {};
        for (int i = 0; i < STR_MAX + 3; i++)
            sa.push_back(CHAR_W'($urandom_range(0, 5)));
        for (int i = 0; i < STR_MAX; i++)
            sb.push_back(CHAR_W'($urandom_range(0, 5)));
        send_pair(sa, sb);
        send_pair(sb, sa);
    endtask

    // Second string as an edited copy of the first, so matches are common.
    task automatic random_pair(int max_len);
        logic [CHAR_W-1:0] sa[$];
        logic [CHAR_W-1:0] sb[$];
        int                na, alpha, j;
        logic [CHAR_W-1:0] tmp;
        sa = {};
        na = $urandom_range(0, max_len);
        alpha = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
        for (int i = 0; i < na; i++)
            sa.push_back(alpha == 0 ? 21'($urandom()) : 21'($urandom_range(0, alpha)));
        sb = sa;
        repeat ($urandom_range(0, 4))
        begin
            case ($urandom_range(0, 3))
                0: if (sb.size() > 1)
                   begin
                       j = $urandom_range(0, sb.size() - 2);
                       tmp = sb[j];
                       sb[j] = sb[j + 1];
                       sb[j + 1] = tmp;
                   end
                1: if (sb.size() > 0)
                       sb.delete($urandom_range(0, sb.size() - 1));
                2: sb.insert($urandom_range(0, sb.size()), 21'($urandom_range(0, 15)));
                default: if (sb.size() > 0)
                             sb[$urandom_range(0, sb.size() - 1)] = 21'($urandom());
            endcase
        end
        if ($urandom_range(0, 9) == 0)
        begin
            // noise: loose items into either string before the pair proper
            repeat ($urandom_range(1, 4))
                send_item(CHAR_W'($urandom()), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'b0);
        end
        send_pair(sa, sb);
    endtask

    task automatic test_random(int n_items);
        int pairs;
        pairs = 0;
        while (items_sent < n_items)
        begin
            if ($urandom_range(0, 7) == 0)
                steady_in = ~steady_in;
            if ($urandom_range(0, 7) == 0)
                steady_out = ~steady_out;
            random_pair(($urandom_range(0, 49) == 0) ? STR_MAX + 4 : 10);
            pairs++;
            if (pairs % 60 == 0)
                write_scale(15'($urandom_range(0, 32767)));
        end
        steady_in = 1'b0;
        steady_out = 1'b0;
    endtask

    // Prefix scale sweep: zero, default, the nominal top and full width.
    task automatic test_scale();
        logic [CHAR_W-1:0] sa[$];
        logic [CHAR_W-1:0] sb[$];
        logic [14:0]       settings[4];
        settings = '{15'd0, 15'd16384, 15'h7FFF, 15'd6554};
        sa = '{"D", "W", "A", "Y", "N", "E"};
        sb = '{"D", "W", "A", "Y", "E", "N", "X"};
        foreach (settings[i])
        begin
            write_scale(settings[i]);
            send_pair(sa, sb);
            send_pair(sa, sa);
        end
    endtask

    // Result side: random stalls and the comparison against the oldest expectation.
    int pop_wait;
    int pop_draw;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop      <= 1'b0;
            pop_wait <= 0;
        end
        else if (pop && empty === 1'b0)
        begin
            if (score_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %p", result);
            end
            else
            begin
                if (result !== score_q[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: sim exp %0d got %0d, m exp %0d got %0d, t exp %0d got %0d, trunc exp %0d got %0d",
                                 score_q[0].similarity, result.similarity,
                                 score_q[0].match_count, result.match_count,
                                 score_q[0].transposition_count, result.transposition_count,
                                 score_q[0].truncated, result.truncated);
                end
                void'(score_q.pop_front());
            end
            pop_draw = steady_out ? 0 : $urandom_range(0, 8);
            pop_wait <= pop_draw;
            if (pop_draw != 0)
                pop <= 1'b0;
        end
        else if (!pop)
        begin
            if (pop_wait <= 1)
                pop <= 1'b1;
            else
                pop_wait <= pop_wait - 1;
        end
    end

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        push       <= 1'b0;
        item       <= '0;
        cfg_we     <= 1'b0;
        cfg_data   <= '0;
        len_a      = 0;
        len_b      = 0;
        cut_seen   = 1'b0;
        scale      = SCALE_RESET;
        mismatches = 0;
        items_sent = 0;
        steady_in  = 1'b0;
        steady_out = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_truncation();
        test_scale();
        test_random(items_sent + RAND_ITEMS);

        wait_quiet();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: worst case is far below this.
    initial
    begin
        #60ms;
        $display("FAILURE");
        $finish;
    end

endmodule
